### rtl/core/gspt_pkg.sv
// ----------------------------------------------------------------------------
// gspt_pkg
// Types, constants and helpers for the SIMD pipeline timing block.
// ----------------------------------------------------------------------------
package gspt_pkg;

  localparam int WAVE_SIZE_DEF   = 64;
  localparam int ISSUE_DEPTH_DEF = 8;
  localparam int READ_DEPTH_DEF  = 4;
  localparam int EXEC_DEPTH_DEF  = 256;
  localparam int MAX_WIDTH_DEF   = 4;
  localparam int RETIRE_PER_TICK = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int WCNT_W     = 4;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_SIMD_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ISSUE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LAT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALU_LAT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUBWAVE_LOG = 3'd5;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REFUSE  = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] uop_tag;
    logic [6:0]  item_count;
    logic [63:0] lane_mask;
    logic [31:0] ready_cycle;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] done_tag;
    logic        last;
    logic [47:0] active_total;
    logic [47:0] mapped_total;
    logic [47:0] considered_total;
    logic [31:0] retired_total;
    logic [31:0] now_cycle;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUT,
    ST_RET_RD,
    ST_RET_CHK,
    ST_EXE,
    ST_EXE_A,
    ST_EXE_B,
    ST_EXE_LD,
    ST_RD,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic enq;
    logic ret_pop;
    logic sub_a;
    logic sub_b;
    logic ld;
    logic rd_mv;
    logic sum;
  } ctl_t;

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [7:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {41'd0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

### rtl/core/gpu_simd_pipeline_timing.sv
// ----------------------------------------------------------------------------
// gpu_simd_pipeline_timing
// Cycle-level SIMD vector-unit pipeline timing model with issue FIFO, read
// buffer, sub-wave execute pool and in-order exec/writeback FIFO.
// ----------------------------------------------------------------------------
// Enqueue: the result is registered on acceptance; ready again after the output
//   transaction.
// Tick: retire checks (each after a registered exec FIFO memory read), then
//   sub-wave execution and pool loads, then issue-to-read-buffer moves, then a
//   summary, all through one sequencer and one sub-wave lane counter.
// Reset: all FIFOs empty, counters and sums zero, no clearing pass.
module gpu_simd_pipeline_timing
  import gspt_pkg::*;
#(
  parameter int WAVE_SIZE   = WAVE_SIZE_DEF,
  parameter int ISSUE_DEPTH = ISSUE_DEPTH_DEF,
  parameter int READ_DEPTH  = READ_DEPTH_DEF,
  parameter int EXEC_DEPTH  = EXEC_DEPTH_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW  = (ISSUE_DEPTH > 1) ? $clog2(ISSUE_DEPTH) : 1;
  localparam int IFW = $clog2(ISSUE_DEPTH + 1);
  localparam int RW  = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;
  localparam int RFW = $clog2(READ_DEPTH + 1);
  localparam int EW  = $clog2(EXEC_DEPTH);
  localparam int EFW = $clog2(EXEC_DEPTH + 1);

  logic [2:0] cfg_width_q, cfg_rlim_q, cfg_log_q;
  logic [3:0] cfg_ilim_q, cfg_rlat_q;
  logic [5:0] cfg_alat_q;

  state_e state_q, state_d, ret_q;
  ctl_t   ctl;

  logic [15:0] iq_tag [ISSUE_DEPTH];
  logic [6:0]  iq_cnt [ISSUE_DEPTH];
  logic [63:0] iq_mask[ISSUE_DEPTH];
  logic [31:0] iq_rdy [ISSUE_DEPTH];
  logic [IW-1:0]  iq_head_q, iq_tail_q;
  logic [IFW-1:0] iq_fill_q;

  logic [15:0] rb_tag [READ_DEPTH];
  logic [6:0]  rb_cnt [READ_DEPTH];
  logic [63:0] rb_mask[READ_DEPTH];
  logic [31:0] rb_rdy [READ_DEPTH];
  logic [RW-1:0]  rb_head_q, rb_tail_q;
  logic [RFW-1:0] rb_fill_q;

  logic [47:0] ex_mem [EXEC_DEPTH];
  logic [47:0] ex_rd_q;
  logic [EW-1:0]  ex_head_q, ex_tail_q;
  logic [EFW-1:0] ex_fill_q;

  logic        pool_valid_q;
  logic [15:0] pool_tag_q;
  logic [6:0]  pool_cnt_q, pool_sub_q;
  logic [63:0] pool_mask_q;

  logic [6:0]  sub_map_q;
  logic [63:0] sub_bits_q;
  logic        sub_last_q;

  logic [47:0] act_q, map_q, con_q;
  logic [31:0] retired_q, cycle_q;
  logic [2:0]  ret_n_q;
  logic [WCNT_W-1:0] exe_n_q, rd_n_q;

  out_t out_q;
  logic out_valid_q;

  logic [WCNT_W-1:0] eff_w;
  logic [6:0]        lsize;
  logic [IFW-1:0]    ilim;
  logic [RFW-1:0]    rlim;
  logic              ret_ok, ld_ok, rd_ok, ex_full, enq_ok;
  logic [13:0]       start;
  logic [6:0]        mapped, diff;
  logic [63:0]       shifted, bits;
  logic              last_sub;
  logic [6:0]        active;

  always_comb begin
    eff_w = (32'(cfg_width_q) > MAX_WIDTH) ? WCNT_W'(MAX_WIDTH) : WCNT_W'(cfg_width_q);
    lsize = 7'(WAVE_SIZE) >> cfg_log_q;
    if (lsize == 7'd0) begin
      lsize = 7'd1;
    end
    ilim = (32'(cfg_ilim_q) > ISSUE_DEPTH) ? IFW'(ISSUE_DEPTH) : IFW'(cfg_ilim_q);
    rlim = (32'(cfg_rlim_q) > READ_DEPTH) ? RFW'(READ_DEPTH) : RFW'(cfg_rlim_q);
    enq_ok  = iq_fill_q < ilim;
    ex_full = 32'(ex_fill_q) >= EXEC_DEPTH;
    ret_ok  = (ex_fill_q != '0) && (32'(ret_n_q) < RETIRE_PER_TICK)
              && (ex_rd_q[31:0] <= cycle_q);
    ld_ok   = (rb_fill_q != '0) && (cycle_q >= rb_rdy[rb_head_q]);
    rd_ok   = (iq_fill_q != '0) && (rd_n_q < eff_w) && (cycle_q >= iq_rdy[iq_head_q])
              && (rb_fill_q < rlim);
  end

  always_comb begin
    start = 14'(lsize) * 14'(pool_sub_q);
    diff  = pool_cnt_q - start[6:0];
    if (14'(pool_cnt_q) > start) begin
      mapped = (diff > lsize) ? lsize : diff;
    end else begin
      mapped = 7'd0;
    end
    shifted = (start < 14'd64) ? (pool_mask_q >> start[5:0]) : 64'd0;
    for (int k = 0; k < 64; k++) begin
      bits[k] = shifted[k] && (7'(k) < mapped);
    end
    last_sub = (start + 14'(lsize)) >= 14'(pool_cnt_q);
    active   = 7'($countones(sub_bits_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_i.action ? ST_OUT : ST_RET_RD;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ret_q;
        end
      end
      ST_RET_RD: state_d = ST_RET_CHK;
      ST_RET_CHK: begin
        if (ret_ok) begin
          state_d = ST_OUT;
        end else begin
          state_d = ex_full ? ST_RD : ST_EXE;
        end
      end
      ST_EXE: begin
        if (exe_n_q >= eff_w) begin
          state_d = ST_RD;
        end else begin
          state_d = pool_valid_q ? ST_EXE_A : ST_EXE_LD;
        end
      end
      ST_EXE_A: state_d = ST_EXE_B;
      ST_EXE_B: state_d = sub_last_q ? ST_EXE_LD : ST_EXE;
      ST_EXE_LD: state_d = ld_ok ? ST_EXE : ST_RD;
      ST_RD: state_d = rd_ok ? ST_RD : ST_SUM;
      ST_SUM: state_d = ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_q)
      ST_IDLE:    ctl.enq = in_valid_i && in_i.action;
      ST_RET_CHK: ctl.ret_pop = ret_ok;
      ST_EXE_A:   ctl.sub_a = 1'b1;
      ST_EXE_B:   ctl.sub_b = 1'b1;
      ST_EXE_LD:  ctl.ld = ld_ok;
      ST_RD:      ctl.rd_mv = rd_ok;
      ST_SUM:     ctl.sum = 1'b1;
      default:    ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.enq && enq_ok) begin
      iq_tag[iq_tail_q]  <= in_i.uop_tag;
      iq_cnt[iq_tail_q]  <= (32'(in_i.item_count) > WAVE_SIZE) ? 7'(WAVE_SIZE)
                                                                 : in_i.item_count;
      iq_mask[iq_tail_q] <= in_i.lane_mask;
      iq_rdy[iq_tail_q]  <= in_i.ready_cycle;
    end
    if (ctl.rd_mv) begin
      rb_tag[rb_tail_q]  <= iq_tag[iq_head_q];
      rb_cnt[rb_tail_q]  <= iq_cnt[iq_head_q];
      rb_mask[rb_tail_q] <= iq_mask[iq_head_q];
      rb_rdy[rb_tail_q]  <= cycle_q + 32'(cfg_rlat_q);
    end
    if (ctl.sub_a) begin
      sub_map_q  <= mapped;
      sub_bits_q <= bits;
      sub_last_q <= last_sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.sub_b && sub_last_q) begin
      ex_mem[ex_tail_q] <= {pool_tag_q, cycle_q + 32'(cfg_alat_q)};
    end
    ex_rd_q <= ex_mem[ex_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 3'd1;
      cfg_ilim_q   <= 4'd5;
      cfg_rlat_q   <= 4'd1;
      cfg_rlim_q   <= 3'd1;
      cfg_alat_q   <= 6'd8;
      cfg_log_q    <= 3'd2;
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      iq_head_q    <= '0;
      iq_tail_q    <= '0;
      iq_fill_q    <= '0;
      rb_head_q    <= '0;
      rb_tail_q    <= '0;
      rb_fill_q    <= '0;
      ex_head_q    <= '0;
      ex_tail_q    <= '0;
      ex_fill_q    <= '0;
      pool_valid_q <= 1'b0;
      pool_tag_q   <= '0;
      pool_cnt_q   <= '0;
      pool_sub_q   <= '0;
      pool_mask_q  <= '0;
      act_q        <= '0;
      map_q        <= '0;
      con_q        <= '0;
      retired_q    <= '0;
      cycle_q      <= '0;
      ret_n_q      <= '0;
      exe_n_q      <= '0;
      rd_n_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIMD_WIDTH:  cfg_width_q <= cfg_data_i[2:0];
          REG_ISSUE_LIMIT: cfg_ilim_q  <= cfg_data_i[3:0];
          REG_READ_LAT:    cfg_rlat_q  <= cfg_data_i[3:0];
          REG_READ_LIMIT:  cfg_rlim_q  <= cfg_data_i[2:0];
          REG_ALU_LAT:     cfg_alat_q  <= cfg_data_i[5:0];
          REG_SUBWAVE_LOG: cfg_log_q   <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE && in_valid_i) begin
        ret_n_q <= '0;
        exe_n_q <= '0;
        rd_n_q  <= '0;
      end
      if (ctl.enq) begin
        out_valid_q            <= 1'b1;
        ret_q                  <= ST_IDLE;
        out_q.kind             <= enq_ok ? KIND_ACCEPT : KIND_REFUSE;
        out_q.done_tag         <= in_i.uop_tag;
        out_q.last             <= 1'b1;
        out_q.active_total     <= act_q;
        out_q.mapped_total     <= map_q;
        out_q.considered_total <= con_q;
        out_q.retired_total    <= retired_q;
        out_q.now_cycle        <= cycle_q;
        if (enq_ok) begin
          iq_fill_q <= iq_fill_q + 1'b1;
          iq_tail_q <= (iq_tail_q == IW'(ISSUE_DEPTH - 1)) ? '0 : iq_tail_q + 1'b1;
        end
      end
      if (ctl.ret_pop) begin
        out_valid_q            <= 1'b1;
        ret_q                  <= ST_RET_RD;
        out_q.kind             <= KIND_DONE;
        out_q.done_tag         <= ex_rd_q[47:32];
        out_q.last             <= 1'b0;
        out_q.active_total     <= act_q;
        out_q.mapped_total     <= map_q;
        out_q.considered_total <= con_q;
        out_q.retired_total    <= retired_q + 32'd1;
        out_q.now_cycle        <= cycle_q;
        retired_q <= retired_q + 32'd1;
        ret_n_q   <= ret_n_q + 3'd1;
        ex_fill_q <= ex_fill_q - 1'b1;
        ex_head_q <= (ex_head_q == EW'(EXEC_DEPTH - 1)) ? '0 : ex_head_q + 1'b1;
      end
      if (ctl.sub_b) begin
        act_q      <= sat48(act_q, {1'b0, active});
        map_q      <= sat48(map_q, {1'b0, sub_map_q});
        con_q      <= sat48(con_q, {1'b0, active} + {1'b0, lsize - sub_map_q});
        exe_n_q    <= exe_n_q + 1'b1;
        pool_sub_q <= pool_sub_q + 7'd1;
        if (sub_last_q) begin
          pool_valid_q <= 1'b0;
          pool_sub_q   <= '0;
          ex_fill_q    <= ex_fill_q + 1'b1;
          ex_tail_q    <= (ex_tail_q == EW'(EXEC_DEPTH - 1)) ? '0 : ex_tail_q + 1'b1;
        end
      end
      if (ctl.ld) begin
        pool_valid_q <= 1'b1;
        pool_tag_q   <= rb_tag[rb_head_q];
        pool_cnt_q   <= rb_cnt[rb_head_q];
        pool_mask_q  <= rb_mask[rb_head_q];
        pool_sub_q   <= '0;
        rb_head_q    <= (rb_head_q == RW'(READ_DEPTH - 1)) ? '0 : rb_head_q + 1'b1;
      end
      if (ctl.rd_mv) begin
        rd_n_q    <= rd_n_q + 1'b1;
        iq_head_q <= (iq_head_q == IW'(ISSUE_DEPTH - 1)) ? '0 : iq_head_q + 1'b1;
        iq_fill_q <= iq_fill_q - 1'b1;
        rb_tail_q <= (rb_tail_q == RW'(READ_DEPTH - 1)) ? '0 : rb_tail_q + 1'b1;
      end
      if (ctl.ld && !ctl.rd_mv) begin
        rb_fill_q <= rb_fill_q - 1'b1;
      end else if (ctl.rd_mv && !ctl.ld) begin
        rb_fill_q <= rb_fill_q + 1'b1;
      end
      if (ctl.sum) begin
        cycle_q                <= cycle_q + 32'd1;
        out_valid_q            <= 1'b1;
        ret_q                  <= ST_IDLE;
        out_q.kind             <= KIND_SUMMARY;
        out_q.done_tag         <= '0;
        out_q.last             <= 1'b1;
        out_q.active_total     <= act_q;
        out_q.mapped_total     <= map_q;
        out_q.considered_total <= con_q;
        out_q.retired_total    <= retired_q;
        out_q.now_cycle        <= cycle_q + 32'd1;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q == (state_q == ST_OUT))
    else $error("output valid out of step with sequencer");
  a_issue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(iq_fill_q) <= ISSUE_DEPTH)
    else $error("issue FIFO overfilled");
  a_read_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rb_fill_q) <= READ_DEPTH)
    else $error("read buffer overfilled");
  a_cycle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SUM) |=> (cycle_q == $past(cycle_q)))
    else $error("cycle counter moved outside summary");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIMD pipeline timing block testbench
// Drives enqueue and tick transactions through the input channel and predicts
// every completion, summary and enqueue response with a cycle-level model of
// the issue FIFO, read buffer, sub-wave pool and exec FIFO. Results are checked
// in order, field by field, across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import gspt_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gpu_simd_pipeline_timing u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  // shadow configuration
  int unsigned width_q, issue_lim_q, read_lat_q, read_lim_q, alu_lat_q, sw_log_q;

  // shadow pipeline state
  logic [31:0] cyc_now;
  in_t         issue_q[$];
  in_t         rbuf_q[$];
  logic [31:0] rbuf_at_q[$];
  logic        pool_busy;
  in_t         pool_uop;
  int unsigned pool_sw;
  logic [15:0] exec_tag_q[$];
  logic [31:0] exec_at_q[$];
  logic [47:0] act_sum, map_sum, con_sum;
  logic [31:0] retired_cnt;

  out_t        expected_q[$];
  in_t         pending_q[$];

  int          sender_idle_pct, receiver_stall_pct;
  bit          hold_req;
  int          hold_left;
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [47:0] add_sat(logic [47:0] a, int unsigned b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic out_t make_result(logic [1:0] k, logic [15:0] tag, logic lst,
                                       logic [31:0] c);
    out_t r;
    r.kind = k;
    r.done_tag = tag;
    r.last = lst;
    r.active_total = act_sum;
    r.mapped_total = map_sum;
    r.considered_total = con_sum;
    r.retired_total = retired_cnt;
    r.now_cycle = c;
    return r;
  endfunction

  task automatic run_subwave(int unsigned sz);
    int unsigned first, mapped, active;
    first = sz * pool_sw;
    mapped = 0;
    active = 0;
    if (pool_uop.item_count > first) begin
      mapped = pool_uop.item_count - first;
      if (mapped > sz) mapped = sz;
    end
    for (int unsigned i = first; i < first + mapped; i++)
      if (i < 64 && pool_uop.lane_mask[i]) active++;
    act_sum = add_sat(act_sum, active);
    map_sum = add_sat(map_sum, mapped);
    con_sum = add_sat(con_sum, active + (sz - mapped));
    pool_sw++;
    if (first + sz >= pool_uop.item_count) begin
      exec_tag_q.push_back(pool_uop.uop_tag);
      exec_at_q.push_back(cyc_now + alu_lat_q);
      pool_busy = 1'b0;
      pool_sw = 0;
    end
  endtask

  task automatic predict_transaction(in_t t);
    int unsigned n, w, sz, cnt, lim;
    if (t.action) begin
      lim = issue_lim_q > ISSUE_DEPTH_DEF ? ISSUE_DEPTH_DEF : issue_lim_q;
      if (issue_q.size() >= lim) begin
        expected_q.push_back(make_result(KIND_REFUSE, t.uop_tag, 1'b1, cyc_now));
      end else begin
        cnt = t.item_count > WAVE_SIZE_DEF ? WAVE_SIZE_DEF : t.item_count;
        t.item_count = cnt[6:0];
        issue_q.push_back(t);
        expected_q.push_back(make_result(KIND_ACCEPT, t.uop_tag, 1'b1, cyc_now));
      end
      return;
    end
    n = 0;
    while (exec_tag_q.size() > 0 && n < RETIRE_PER_TICK && exec_at_q[0] <= cyc_now) begin
      retired_cnt++;
      expected_q.push_back(make_result(KIND_DONE, exec_tag_q.pop_front(), 1'b0, cyc_now));
      void'(exec_at_q.pop_front());
      n++;
    end
    w = width_q > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_q;
    sz = WAVE_SIZE_DEF >> sw_log_q;
    if (sz == 0) sz = 1;
    if (exec_tag_q.size() < EXEC_DEPTH_DEF) begin
      n = 0;
      while (n < w) begin
        if (pool_busy) begin
          run_subwave(sz);
          n++;
          if (pool_busy) continue;
        end
        if (rbuf_q.size() == 0 || cyc_now < rbuf_at_q[0]) break;
        pool_busy = 1'b1;
        pool_uop = rbuf_q.pop_front();
        void'(rbuf_at_q.pop_front());
        pool_sw = 0;
      end
    end
    lim = read_lim_q > READ_DEPTH_DEF ? READ_DEPTH_DEF : read_lim_q;
    n = 0;
    while (issue_q.size() > 0 && n < w) begin
      if (cyc_now < issue_q[0].ready_cycle || rbuf_q.size() >= lim) break;
      rbuf_q.push_back(issue_q.pop_front());
      rbuf_at_q.push_back(cyc_now + read_lat_q);
      n++;
    end
    cyc_now++;
    expected_q.push_back(make_result(KIND_SUMMARY, 16'd0, 1'b1, cyc_now));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_transaction(in_i);
      if ((!in_valid_i || in_ready_o) && pending_q.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_i <= pending_q.pop_front();
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_o) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, out_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_ready_i <= (hold_left == 0 && !hold_req) &&
                     ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIMD_WIDTH:  width_q = val & 7;
      REG_ISSUE_LIMIT: issue_lim_q = val & 15;
      REG_READ_LAT:    read_lat_q = val & 15;
      REG_READ_LIMIT:  read_lim_q = val & 7;
      REG_ALU_LAT:     alu_lat_q = val & 63;
      default:         sw_log_q = val & 7;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned il, int unsigned rl,
                           int unsigned rb, int unsigned al, int unsigned sl);
    write_reg(REG_SIMD_WIDTH, w);
    write_reg(REG_ISSUE_LIMIT, il);
    write_reg(REG_READ_LAT, rl);
    write_reg(REG_READ_LIMIT, rb);
    write_reg(REG_ALU_LAT, al);
    write_reg(REG_SUBWAVE_LOG, sl);
  endtask

  function automatic in_t enqueue_item(logic [15:0] tag, logic [6:0] cnt,
                                       logic [63:0] mask, logic [31:0] rdy);
    in_t t;
    t.action = 1'b1;
    t.uop_tag = tag;
    t.item_count = cnt;
    t.lane_mask = mask;
    t.ready_cycle = rdy;
    return t;
  endfunction

  function automatic in_t tick_item();
    in_t t;
    t = '0;
    t.lane_mask = {$urandom, $urandom};
    t.uop_tag = $urandom;
    return t;
  endfunction

  function automatic in_t random_enqueue();
    logic [6:0] cnt;
    logic [31:0] rdy;
    case ($urandom_range(9))
      0: cnt = 7'($urandom_range(127));
      1: cnt = 7'd0;
      default: cnt = 7'($urandom_range(64, 1));
    endcase
    rdy = ($urandom_range(9) == 0) ? $urandom : cyc_now + $urandom_range(20);
    return enqueue_item($urandom, cnt, {$urandom, $urandom}, rdy);
  endfunction

  // wait for drain, then for any work that produces no result
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned items, int sidle, int rstall);
    sender_idle_pct = sidle;
    receiver_stall_pct = rstall;
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(99) < 35) pending_q.push_back(random_enqueue());
      else pending_q.push_back(tick_item());
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    timed_out = 1'b0;
    hold_req = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    width_q = 1;
    issue_lim_q = 5;
    read_lat_q = 1;
    read_lim_q = 1;
    alu_lat_q = 8;
    sw_log_q = 2;
    cyc_now = '0;
    pool_busy = 1'b0;
    pool_uop = '0;
    pool_sw = 0;
    act_sum = '0;
    map_sum = '0;
    con_sum = '0;
    retired_cnt = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes of fields, refusal, zero and oversize counts
    pending_q.push_back(enqueue_item(16'hFFFF, 7'd64, '1, 32'd0));
    pending_q.push_back(enqueue_item(16'h0000, 7'd1, '0, 32'd0));
    pending_q.push_back(enqueue_item(16'h1234, 7'd0, 64'hAAAA_AAAA_5555_5555, 32'd2));
    pending_q.push_back(enqueue_item(16'h5A5A, 7'd127, '1, 32'd3));
    pending_q.push_back(enqueue_item(16'hA5A5, 7'd33, 64'h0F0F_F0F0_0F0F_F0F0, 32'd1));
    pending_q.push_back(enqueue_item(16'hBEEF, 7'd5, '1, 32'hFFFF_FFFF));
    repeat (18) pending_q.push_back(tick_item());
    drain();

    configure(4, 8, 0, 4, 0, 6);
    for (int i = 0; i < 4; i++) pending_q.push_back(random_enqueue());
    repeat (8) pending_q.push_back(tick_item());
    drain();

    configure(7, 15, 15, 7, 63, 7);
    random_phase(60, 0, 0);
    configure(0, 0, 3, 0, 1, 0);
    random_phase(15, 0, 0);
    configure(2, 6, 2, 2, 5, 3);
    random_phase(70, 48, 0);
    configure(4, 8, 1, 4, 3, 1);
    random_phase(70, 0, 48);
    configure(3, 4, 0, 3, 10, 4);
    random_phase(70, 11, 11);

    // fill the pipeline while the receiver holds off
    configure(1, 8, 4, 1, 20, 5);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) pending_q.push_back(random_enqueue());
      else pending_q.push_back(tick_item());
    end
    @(posedge clk_i);
    @(posedge clk_i);
    hold_req = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/gspt_pkg.sv
rtl/core/gpu_simd_pipeline_timing.sv
bench/testbench.sv
